/* design/analog_keypad_gain_editor_top_defines.svh */
// Assertion macros for the analog keypad gain editor.
// No dependencies; included by the files that carry assertions.
`ifndef ANALOG_KEYPAD_GAIN_EDITOR_TOP_DEFINES_SVH
`define ANALOG_KEYPAD_GAIN_EDITOR_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AKGE_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("akge assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define AKGE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("akge assertion failed");

`endif

/* design/akge_pkg.sv */
// Shared types and constants for the analog keypad gain editor.
// No dependencies; imported by akge_classify and the top level.
package akge_pkg;

    localparam int MENU_ENTRIES = 13;
    localparam int MENU_W       = 4;
    localparam int CFG_IDX_W    = 4;
    localparam int CFG_DATA_W   = 16;

    typedef enum logic [2:0] {
        KEY_UP        = 3'd0,
        KEY_DOWN      = 3'd1,
        KEY_LEFT      = 3'd2,
        KEY_RIGHT     = 3'd3,
        KEY_CLICK     = 3'd4,
        KEY_NONE      = 3'd5,
        KEY_UNSETTLED = 3'd6
    } t_key;

    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_LOAD = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_THR_UP       = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THR_DOWN     = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THR_LEFT     = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_THR_RIGHT    = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_THR_CLICK    = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_STEP    = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_INC_LIM = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_LIM   = 4'd7;

    localparam logic signed [15:0] THR_UP_RST    = -16'sd24228;
    localparam logic signed [15:0] THR_DOWN_RST  = -16'sd9532;
    localparam logic signed [15:0] THR_LEFT_RST  = 16'sd3377;
    localparam logic signed [15:0] THR_RIGHT_RST = 16'sd14696;
    localparam logic signed [15:0] THR_CLICK_RST = 16'sd24030;
    localparam logic [15:0]        GAIN_STEP_RST = 16'd81;
    localparam logic [15:0]        GAIN_INC_RST  = 16'd65455;
    localparam logic [7:0]         REPEAT_RST    = 8'd10;

    typedef struct packed {
        logic signed [15:0] up;
        logic signed [15:0] down;
        logic signed [15:0] left;
        logic signed [15:0] right;
        logic signed [15:0] click;
    } t_thr;

endpackage

/* design/akge_classify.sv */
// Keypad level decoder: compares one sample against the five thresholds.
// Depends on akge_pkg.
module akge_classify
    import akge_pkg::*;
(
    input  logic signed [15:0] i_sample,
    input  t_thr               i_thr,
    output t_key               o_level
);

    always_comb begin
        if (i_sample < i_thr.up) begin
            o_level = KEY_UP;
        end else if (i_sample < i_thr.down) begin
            o_level = KEY_DOWN;
        end else if (i_sample < i_thr.left) begin
            o_level = KEY_LEFT;
        end else if (i_sample < i_thr.right) begin
            o_level = KEY_RIGHT;
        end else if (i_sample < i_thr.click) begin
            o_level = KEY_CLICK;
        end else begin
            o_level = KEY_NONE;
        end
    end

endmodule

/* design/analog_keypad_gain_editor_top.sv */
// Top level of the analog keypad gain editor: debounce, auto-repeat, menu and gains.
// Depends on akge_pkg, akge_classify and analog_keypad_gain_editor_top_defines.svh.
//
// Usage:
//  Input channel (i_in_valid / o_in_ready) carries tick transactions (keypad sample)
//  and load transactions (gain table entry). Every input transaction yields exactly
//  one result transaction on the output channel (o_out_valid / i_out_ready).
//  The result register holds the answer in the cycle after acceptance. Throughput
//  is one transaction per cycle while the receiver takes each result; the state
//  update and the result are computed by the logic between the state registers and
//  the result register, so only a receiver stall holds the rate below one per cycle.
//  When the receiver stalls, the result register holds and o_in_ready drops; it
//  rises again in the cycle the result is taken, so a new transaction can be accepted in that cycle.
//  Reset (synchronous, active low) restores the register defaults, clears the
//  debounce, repeat and menu state, arms the first mode toggle and empties the
//  result register. The gain table is not cleared and must be loaded before use.
//  Configuration writes (i_cfg_we, i_cfg_index, i_cfg_data) take effect at once
//  and are meant to be issued while the block is idle.
`include "analog_keypad_gain_editor_top_defines.svh"

module analog_keypad_gain_editor_top
    import akge_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_req_type,
    input  logic signed [15:0]    i_sample,
    input  logic [3:0]            i_load_index,
    input  logic [15:0]           i_load_value,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [2:0]            o_key_code,
    output logic [3:0]            o_menu_index,
    output logic [15:0]           o_selected_gain,
    output logic                  o_display_active,
    output logic                  o_display_refresh,
    output logic                  o_store_request
);

    t_thr        r_thr;
    logic [15:0] r_gain_step;
    logic [15:0] r_gain_inc_limit;
    logic [7:0]  r_repeat_limit;

    t_key              r_prior_level, n_prior_level;
    t_key              r_last_key, n_last_key;
    logic [7:0]        r_hold_count, n_hold_count;
    logic              r_repeat_flag, n_repeat_flag;
    logic [MENU_W-1:0] r_menu_pos, n_menu_pos;
    logic              r_toggle_pending, n_toggle_pending;
    logic              r_mode_on, n_mode_on;
    logic [15:0]       r_gain_table [MENU_ENTRIES];

    logic              r_out_valid;
    t_key              r_key_code, n_key_code;
    logic [MENU_W-1:0] r_menu_index;
    logic [15:0]       r_selected_gain, n_selected_gain;
    logic              r_display_active;
    logic              r_display_refresh, n_display_refresh;
    logic              r_store_request, n_store_request;

    t_key              level;
    logic              in_acc;
    logic [7:0]        hold_inc;
    logic              fire;
    logic              toggle;
    logic [15:0]       cur_gain;
    logic              wr_en;
    logic [MENU_W-1:0] wr_idx;
    logic [15:0]       wr_data;

    akge_classify u_classify (
        .i_sample (i_sample),
        .i_thr    (r_thr),
        .o_level  (level)
    );

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_acc     = i_in_valid && o_in_ready;
    assign cur_gain   = r_gain_table[r_menu_pos];
    assign hold_inc   = r_hold_count + 8'd1;

    always_comb begin
        n_prior_level     = r_prior_level;
        n_last_key        = r_last_key;
        n_hold_count      = r_hold_count;
        n_repeat_flag     = r_repeat_flag;
        n_menu_pos        = r_menu_pos;
        n_toggle_pending  = r_toggle_pending;
        n_mode_on         = r_mode_on;
        n_key_code        = KEY_NONE;
        n_display_refresh = 1'b0;
        n_store_request   = 1'b0;
        wr_en             = 1'b0;
        wr_idx            = r_menu_pos;
        wr_data           = i_load_value;
        fire              = 1'b0;
        toggle            = 1'b0;

        if (i_req_type == REQ_LOAD) begin
            if (i_load_index < 4'(MENU_ENTRIES)) begin
                wr_en  = 1'b1;
                wr_idx = i_load_index;
            end
        end else begin
            if (level != r_prior_level) begin
                n_prior_level = level;
                n_key_code    = KEY_UNSETTLED;
            end else begin
                n_key_code = level;
                if (level != KEY_CLICK) begin
                    if (hold_inc > r_repeat_limit) begin
                        n_repeat_flag = 1'b1;
                        n_hold_count  = '0;
                    end else begin
                        n_hold_count = hold_inc;
                    end
                end
                fire = (level != r_last_key) || n_repeat_flag;
                if (fire) begin
                    n_repeat_flag = 1'b0;
                    n_last_key    = level;
                    case (level)
                        KEY_LEFT: begin
                            if (r_menu_pos != '0) begin
                                n_menu_pos = r_menu_pos - 1'b1;
                            end
                        end
                        KEY_RIGHT: begin
                            if (r_menu_pos < MENU_W'(MENU_ENTRIES - 1)) begin
                                n_menu_pos = r_menu_pos + 1'b1;
                            end
                        end
                        KEY_UP: begin
                            if (cur_gain <= r_gain_inc_limit) begin
                                wr_en   = 1'b1;
                                wr_data = cur_gain + r_gain_step;
                            end
                        end
                        KEY_DOWN: begin
                            if (cur_gain >= r_gain_step) begin
                                wr_en   = 1'b1;
                                wr_data = cur_gain - r_gain_step;
                            end
                        end
                        KEY_CLICK: n_toggle_pending = 1'b1;
                        default: ;
                    endcase
                end
            end
            toggle = n_toggle_pending;
            if (toggle) begin
                n_toggle_pending = 1'b0;
                n_mode_on        = !r_mode_on;
                n_display_refresh = !r_mode_on;
                n_store_request   = r_mode_on;
            end
            if (n_mode_on && (n_key_code != KEY_NONE)) begin
                n_display_refresh = 1'b1;
            end
        end

        if (wr_en && (wr_idx == n_menu_pos)) begin
            n_selected_gain = wr_data;
        end else begin
            n_selected_gain = r_gain_table[n_menu_pos];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr.up         <= THR_UP_RST;
            r_thr.down       <= THR_DOWN_RST;
            r_thr.left       <= THR_LEFT_RST;
            r_thr.right      <= THR_RIGHT_RST;
            r_thr.click      <= THR_CLICK_RST;
            r_gain_step      <= GAIN_STEP_RST;
            r_gain_inc_limit <= GAIN_INC_RST;
            r_repeat_limit   <= REPEAT_RST;
            r_prior_level    <= KEY_UP;
            r_last_key       <= KEY_UP;
            r_hold_count     <= '0;
            r_repeat_flag    <= 1'b0;
            r_menu_pos       <= '0;
            r_toggle_pending <= 1'b1;
            r_mode_on        <= 1'b0;
            r_out_valid      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_THR_UP:       r_thr.up         <= i_cfg_data;
                    CFG_THR_DOWN:     r_thr.down       <= i_cfg_data;
                    CFG_THR_LEFT:     r_thr.left       <= i_cfg_data;
                    CFG_THR_RIGHT:    r_thr.right      <= i_cfg_data;
                    CFG_THR_CLICK:    r_thr.click      <= i_cfg_data;
                    CFG_GAIN_STEP:    r_gain_step      <= i_cfg_data;
                    CFG_GAIN_INC_LIM: r_gain_inc_limit <= i_cfg_data;
                    CFG_REPEAT_LIM:   r_repeat_limit   <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (in_acc) begin
                r_prior_level    <= n_prior_level;
                r_last_key       <= n_last_key;
                r_hold_count     <= n_hold_count;
                r_repeat_flag    <= n_repeat_flag;
                r_menu_pos       <= n_menu_pos;
                r_toggle_pending <= n_toggle_pending;
                r_mode_on        <= n_mode_on;
                r_out_valid      <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // gain table and result payload, no reset
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            if (wr_en) begin
                r_gain_table[wr_idx] <= wr_data;
            end
            r_key_code        <= n_key_code;
            r_menu_index      <= n_menu_pos;
            r_selected_gain   <= n_selected_gain;
            r_display_active  <= n_mode_on;
            r_display_refresh <= n_display_refresh;
            r_store_request   <= n_store_request;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_key_code        = r_key_code;
    assign o_menu_index      = r_menu_index;
    assign o_selected_gain   = r_selected_gain;
    assign o_display_active  = r_display_active;
    assign o_display_refresh = r_display_refresh;
    assign o_store_request   = r_store_request;

    `AKGE_ASSERT_NOW(a_menu_in_range, i_clk, i_rst_n, 1'b1,
        r_menu_pos < MENU_W'(MENU_ENTRIES))
    `AKGE_ASSERT_NOW(a_store_refresh_excl, i_clk, i_rst_n, r_out_valid,
        !(r_store_request && r_display_refresh))
    `AKGE_ASSERT_NOW(a_store_mode_off, i_clk, i_rst_n, r_out_valid && r_store_request,
        !r_display_active)
    `AKGE_ASSERT_NEXT(a_toggle_consumed, i_clk, i_rst_n, in_acc && (i_req_type == REQ_TICK),
        !r_toggle_pending && (r_display_active == r_mode_on))

endmodule
